// ===== rtl/core/cbrd_pkg.sv =====
// Shared types and constants for the cwnd bandwidth-ratio decision block.
// No dependencies; used by cbrd_post and the top level.
package cbrd_pkg;

	// Time saturation width; delay and fair time clamp at 2**TIME_BITS - 1
	localparam int TIME_BITS  = 48;
	localparam int TIME_HALF  = TIME_BITS / 2;
	// One quotient bit per stage, deepest divider sets the depth
	localparam int DIV_DEPTH  = 48;

	localparam int IN_BYTES   = 28;
	localparam int OUT_BYTES  = 43;
	localparam int IN_W       = IN_BYTES * 8;
	localparam int OUT_W      = OUT_BYTES * 8;

	localparam logic [31:0] HIGH_RESET = 32'd131072;
	localparam logic [16:0] LOW_RESET  = 17'd32768;
	localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
	localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;

	typedef enum logic {
		REG_HIGH = 1'b0,
		REG_LOW  = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_DECREASE = 2'd1,
		ACT_INCREASE = 2'd2,
		ACT_TCP      = 2'd3
	} action_t;

	// Per-item data carried alongside the dividers
	typedef struct packed {
		logic        inv;
		logic        ovf;
		logic [15:0] n;
		logic [15:0] seg;
		logic [31:0] win;
		logic [31:0] free_b;
	} side_t;

	// Result word; last member sits in the lowest bits
	typedef struct packed {
		logic [47:0] fair_time_ns;
		logic [47:0] free_window_packets;
		logic [31:0] free_window_bytes;
		logic [46:0] mean_tx_ns;
		logic [31:0] share_ratio;
		logic [31:0] real_share;
		logic [16:0] fair_share;
		logic [47:0] delay_ns;
		logic [31:0] new_window_bytes;
		action_t     action;
	} result_t;

endpackage

// ===== rtl/core/cbrd_div_lane.sv =====
// Pipelined restoring divider, one quotient bit per register stage over its last NUM_W stages.
// Depends on nothing; instantiated by the top level once per quotient and once for the cap remainder.
module cbrd_div_lane #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16,
	parameter int DEPTH = 48
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [DEN_W-1:0] rem_init,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);
	// Lane idles (passes operands) until it has exactly NUM_W stages left
	localparam int START = DEPTH - NUM_W;

	logic [NUM_W-1:0] a_s [DEPTH];
	logic [DEN_W-1:0] r_s [DEPTH];
	logic [DEN_W-1:0] d_s [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		logic [NUM_W-1:0] a_in, a_nx;
		logic [DEN_W-1:0] r_in, r_nx, d_in;

		if (k == 0) begin : g_first
			assign a_in = num;
			assign r_in = rem_init;
			assign d_in = den;
		end else begin : g_next
			assign a_in = a_s[k-1];
			assign r_in = r_s[k-1];
			assign d_in = d_s[k-1];
		end

		if (k >= START) begin : g_step
			logic [DEN_W:0] t;
			logic [DEN_W:0] diff;
			always_comb begin
				t    = {r_in, a_in[NUM_W-1]};
				diff = t - {1'b0, d_in};
				if (t >= {1'b0, d_in}) begin
					r_nx = diff[DEN_W-1:0];
					a_nx = {a_in[NUM_W-2:0], 1'b1};
				end else begin
					r_nx = t[DEN_W-1:0];
					a_nx = {a_in[NUM_W-2:0], 1'b0};
				end
			end
		end else begin : g_pass
			assign a_nx = a_in;
			assign r_nx = r_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k] <= a_nx;
				r_s[k] <= r_nx;
				d_s[k] <= d_in;
			end
		end
	end

	assign quot = a_s[DEPTH-1];
	assign rem  = r_s[DEPTH-1];

endmodule

// ===== rtl/core/cbrd_post.sv =====
// Post-divide pipeline: saturation, products, fair time, delay and decision.
// Depends on cbrd_pkg; instantiated by the top level.
module cbrd_post (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  cbrd_pkg::side_t      side,
	input  logic [16:0]          fair_q,
	input  logic [31:0]          real_q,
	input  logic [46:0]          mean_q,
	input  logic [47:0]          fp_q,
	input  logic [15:0]          cap_rem,
	input  logic [31:0]          high_thr,
	input  logic [16:0]          low_thr,
	output logic                 vld_out,
	output cbrd_pkg::result_t    res
);
	import cbrd_pkg::*;

	typedef struct packed {
		side_t       side;
		logic [16:0] fair;
		logic [31:0] real_share;
		logic [46:0] mean;
		logic [47:0] free_p;
		logic [31:0] cap;
	} carry_t;

	localparam int DW = 32 + TIME_BITS;

	logic   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	carry_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic [47:0] rprod_s1;
	logic [63:0] nfp_s1;
	logic [31:0] ratio_s2, ratio_s3, ratio_s4, ratio_s5, ratio_s6;
	logic [55:0] pp00_s2, pp10_s2;
	logic [54:0] pp01_s2, pp11_s2;
	logic [79:0] lo_s3, hi_s3;
	logic [111:0] tot_s4;
	logic [TIME_BITS-1:0] ft_s5, ft_s6;
	logic [31+TIME_HALF:0] d0_s6;
	logic [31+TIME_BITS-TIME_HALF:0] d1_s6;

	logic [31:0] real_sat;
	carry_t      c_in;

	always_comb begin
		real_sat        = side.ovf ? U32_MAX : real_q;
		c_in.side       = side;
		c_in.fair       = fair_q;
		c_in.real_share = real_sat;
		c_in.mean       = mean_q;
		c_in.free_p     = fp_q;
		c_in.cap        = U32_MAX - {16'd0, cap_rem};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			vld_out <= v_s6;
		end
	end

	// Fair time = n * free_p * mean / 2^16, product split into 32 x 24 pieces
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1     <= c_in;
			rprod_s1 <= real_sat * side.n;
			nfp_s1   <= fp_q * side.n;

			c_s2     <= c_s1;
			ratio_s2 <= (|rprod_s1[47:32]) ? U32_MAX : rprod_s1[31:0];
			pp00_s2  <= nfp_s1[31:0]  * c_s1.mean[23:0];
			pp01_s2  <= nfp_s1[31:0]  * c_s1.mean[46:24];
			pp10_s2  <= nfp_s1[63:32] * c_s1.mean[23:0];
			pp11_s2  <= nfp_s1[63:32] * c_s1.mean[46:24];

			c_s3     <= c_s2;
			ratio_s3 <= ratio_s2;
			lo_s3    <= 80'(pp00_s2) + (80'(pp01_s2) << 24);
			hi_s3    <= 80'(pp10_s2) + (80'(pp11_s2) << 24);

			c_s4     <= c_s3;
			ratio_s4 <= ratio_s3;
			tot_s4   <= 112'(lo_s3) + (112'(hi_s3) << 32);

			c_s5     <= c_s4;
			ratio_s5 <= ratio_s4;
			ft_s5    <= (|tot_s4[111:16+TIME_BITS]) ? '1 : tot_s4[16 +: TIME_BITS];

			c_s6     <= c_s5;
			ratio_s6 <= ratio_s5;
			ft_s6    <= ft_s5;
			d0_s6    <= ratio_s5 * ft_s5[TIME_HALF-1:0];
			d1_s6    <= ratio_s5 * ft_s5[TIME_BITS-1:TIME_HALF];
		end
	end

	logic [DW-1:0]        dsum;
	logic [TIME_BITS-1:0] delay;
	logic [31:0]          seg32, wms, grown_cap;
	logic [32:0]          grown;
	result_t              res_d;

	always_comb begin
		dsum  = DW'(d0_s6) + (DW'(d1_s6) << TIME_HALF);
		delay = (|dsum[DW-1:16+TIME_BITS]) ? '1 : dsum[16 +: TIME_BITS];
		seg32 = {16'd0, c_s6.side.seg};
		wms   = c_s6.side.win - seg32;
		grown = {1'b0, c_s6.side.win} + {1'b0, seg32};
		grown_cap = (grown < {1'b0, c_s6.cap}) ? grown[31:0] : c_s6.cap;

		res_d.fair_time_ns        = 48'(ft_s6);
		res_d.free_window_packets = c_s6.free_p;
		res_d.free_window_bytes   = c_s6.side.free_b;
		res_d.mean_tx_ns          = c_s6.mean;
		res_d.share_ratio         = ratio_s6;
		res_d.real_share          = c_s6.real_share;
		res_d.fair_share          = c_s6.fair;
		res_d.delay_ns            = '0;
		res_d.new_window_bytes    = c_s6.side.win;
		res_d.action              = ACT_TCP;

		priority if (c_s6.side.inv) begin
			res_d                  = '0;
			res_d.action           = ACT_NONE;
			res_d.new_window_bytes = c_s6.side.win;
		end else if (ratio_s6 > high_thr) begin
			res_d.action           = ACT_DECREASE;
			res_d.new_window_bytes = (wms > seg32) ? wms : seg32;
			res_d.delay_ns         = 48'(delay);
		end else if (ratio_s6 < {15'd0, low_thr}) begin
			res_d.action           = ACT_INCREASE;
			res_d.new_window_bytes = grown_cap;
		end else begin
			res_d.action           = ACT_TCP;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res_d;
		end
	end

endmodule

// ===== rtl/core/cwnd_bandwidth_ratio_decision.sv =====
// Top level: config registers, input checks, divider lanes and post pipeline.
// Depends on cbrd_pkg, cbrd_div_lane and cbrd_post.
//
// Takes one flow report word per clock while not held and returns one decision word per report,
// in order, after 48 stages for the dividers (one quotient bit per
// stage, the 48-bit free-packets quotient being the longest) and 7 stages for
// saturation, the fair-time and delay products and the decision. The whole
// pipeline advances together; it holds only while the output word waits.
// Threshold writes take effect at once and belong while the block is empty.
module cwnd_bandwidth_ratio_decision (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// active_time_ns[47:0], period_ns[94:48], packet_count[126:95],
	// flow_total[142:127], segment_bytes[158:143], window_bytes_in[190:159],
	// in_flight_bytes[222:191], zero pad[223]
	input  logic [cbrd_pkg::IN_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// action[1:0], new_window_bytes[33:2], delay_ns[81:34], fair_share[98:82],
	// real_share[130:99], share_ratio[162:131], mean_tx_ns[209:163],
	// free_window_bytes[241:210], free_window_packets[289:242],
	// fair_time_ns[337:290], zero pad[343:338]
	output logic [cbrd_pkg::OUT_W-1:0] m_tdata
);
	import cbrd_pkg::*;

	logic [31:0] high_q;
	logic [16:0] low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= HIGH_RESET;
			low_q  <= LOW_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_HIGH: high_q <= cfg_data;
				REG_LOW:  low_q  <= cfg_data[16:0];
			endcase
		end
	end

	logic [47:0] active;
	logic [46:0] period;
	logic [31:0] packets, win, infl, free_b;
	logic [15:0] n, seg;
	side_t       side_in;
	logic        en;

	assign active  = s_tdata[47:0];
	assign period  = s_tdata[94:48];
	assign packets = s_tdata[126:95];
	assign n       = s_tdata[142:127];
	assign seg     = s_tdata[158:143];
	assign win     = s_tdata[190:159];
	assign infl    = s_tdata[222:191];
	assign free_b  = win - infl;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		side_in.inv = active[47] || (period == '0) || (packets == '0) || (n == '0)
			|| (seg == '0) || (win < {16'd0, seg}) || (infl > win)
			|| (low_q > ONE_Q16[16:0]) || (high_q < ONE_Q16);
		// real share would need more than 32 integer+fraction bits
		side_in.ovf    = {16'd0, active[46:16]} >= period;
		side_in.n      = n;
		side_in.seg    = seg;
		side_in.win    = win;
		side_in.free_b = free_b;
	end

	logic  vld_s  [DIV_DEPTH];
	side_t side_s [DIV_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_DEPTH; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int k = 1; k < DIV_DEPTH; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < DIV_DEPTH; k++) side_s[k] <= side_s[k-1];
		end
	end

	logic [16:0] fair_q;
	logic [31:0] real_q;
	logic [46:0] mean_q;
	logic [47:0] fp_q;
	logic [15:0] cap_rem;
	logic [15:0] fair_rem;
	logic [46:0] real_rem;
	logic [31:0] mean_rem;
	logic [15:0] fp_rem;
	logic [31:0] cap_quot;

	cbrd_div_lane #(.NUM_W(17), .DEN_W(16), .DEPTH(DIV_DEPTH)) u_fair (
		.clk(clk), .en(en), .num(17'h1_0000), .den(n), .rem_init(16'd0),
		.quot(fair_q), .rem(fair_rem)
	);

	cbrd_div_lane #(.NUM_W(32), .DEN_W(47), .DEPTH(DIV_DEPTH)) u_real (
		.clk(clk), .en(en), .num({active[15:0], 16'd0}), .den(period),
		.rem_init({16'd0, active[46:16]}), .quot(real_q), .rem(real_rem)
	);

	cbrd_div_lane #(.NUM_W(47), .DEN_W(32), .DEPTH(DIV_DEPTH)) u_mean (
		.clk(clk), .en(en), .num(active[46:0]), .den(packets), .rem_init(32'd0),
		.quot(mean_q), .rem(mean_rem)
	);

	cbrd_div_lane #(.NUM_W(48), .DEN_W(16), .DEPTH(DIV_DEPTH)) u_fpkt (
		.clk(clk), .en(en), .num({free_b, 16'd0}), .den(seg), .rem_init(16'd0),
		.quot(fp_q), .rem(fp_rem)
	);

	// remainder of all-ones by the segment gives the window cap
	cbrd_div_lane #(.NUM_W(32), .DEN_W(16), .DEPTH(DIV_DEPTH)) u_cap (
		.clk(clk), .en(en), .num(U32_MAX), .den(seg), .rem_init(16'd0),
		.quot(cap_quot), .rem(cap_rem)
	);

	result_t res;

	cbrd_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s[DIV_DEPTH-1]),
		.side     (side_s[DIV_DEPTH-1]),
		.fair_q   (fair_q),
		.real_q   (real_q),
		.mean_q   (mean_q),
		.fp_q     (fp_q),
		.cap_rem  (cap_rem),
		.high_thr (high_q),
		.low_thr  (low_q),
		.vld_out  (m_tvalid),
		.res      (res)
	);

	assign m_tdata = {(OUT_W - $bits(result_t))'(0), res};

	a_decrease_above_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.action == ACT_DECREASE) |-> res.share_ratio > high_q)
		else $error("decrease word with ratio not above high threshold");

	a_increase_below_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.action == ACT_INCREASE)
		|-> (res.share_ratio < {15'd0, low_q}) && (res.delay_ns == '0))
		else $error("increase word with bad ratio or non-zero delay");

	a_none_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.action == ACT_NONE)
		|-> (res.share_ratio == '0) && (res.real_share == '0) && (res.fair_time_ns == '0))
		else $error("no-decision word carries non-zero fields");

	a_tcp_keeps_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.action == ACT_TCP)
		|-> (res.delay_ns == '0) && (res.share_ratio <= high_q))
		else $error("original-tcp word inconsistent with thresholds");

endmodule
